[src/bound_table_with_checkpoint_core_defines.svh]
// Assertion macros for the bound table with checkpoint core.
`ifndef BOUND_TABLE_WITH_CHECKPOINT_CORE_DEFINES_SVH
`define BOUND_TABLE_WITH_CHECKPOINT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BTC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bound table assertion failed");
`define BTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bound table assertion failed");
`else
`define BTC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/btc_pkg.sv]
// Shared types, codes and constants of the bound table with checkpoint core.
package btc_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int IDX_W = 6;
  localparam int BND_W = 32;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER    = 3'd0,
    OP_UPDATE      = 3'd1,
    OP_SAVE_ALL    = 3'd2,
    OP_SAVE_ONE    = 3'd3,
    OP_DISCARD_ALL = 3'd4,
    OP_READ        = 3'd5,
    OP_LIST        = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_NOREG = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         var_out;
    logic signed [BND_W-1:0]  cur_lower;
    logic signed [BND_W-1:0]  cur_upper;
    logic signed [BND_W-1:0]  saved_lower;
    logic signed [BND_W-1:0]  saved_upper;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic latch_in;
    logic rd_idx;
    logic point_exec;
    logic ord_rd;
    logic ent_rd;
    logic walk_exec;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_done;
    logic walk_stall;
  } sts_t;

endpackage

[src/btc_ram.sv]
// Generic simple dual-port RAM with registered read data.
module btc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/btc_ctrl.sv]
// Controller state machine that sequences point operations and table walks.
module btc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  btc_pkg::op_e   op_i,
  output logic           in_ready_o,
  input  btc_pkg::sts_t  sts_i,
  output btc_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PEX  = 3'd2;
  localparam logic [2:0] S_ORD  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_WEX  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (op_i)
            btc_pkg::OP_REGISTER,
            btc_pkg::OP_UPDATE,
            btc_pkg::OP_SAVE_ONE,
            btc_pkg::OP_READ: state_d = S_PRD;
            btc_pkg::OP_SAVE_ALL,
            btc_pkg::OP_DISCARD_ALL,
            btc_pkg::OP_LIST: state_d = S_ORD;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_PRD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_PEX;
      end
      S_PEX: begin
        if (sts_i.out_free) begin
          cmd_o.point_exec = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_ORD: begin
        if (sts_i.walk_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.ord_rd = 1'b1;
          state_d      = S_ERD;
        end
      end
      S_ERD: begin
        cmd_o.ent_rd = 1'b1;
        state_d      = S_WEX;
      end
      S_WEX: begin
        if (!sts_i.walk_stall) begin
          cmd_o.walk_exec = 1'b1;
          state_d         = S_ORD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/btc_dp.sv]
// Datapath: bound memories, registration order, valid bits and result registers.
module btc_dp #(
  parameter int NUM_ENTRIES = btc_pkg::NUM_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btc_pkg::cmd_t                       cmd_i,
  output btc_pkg::sts_t                       sts_o,
  input  btc_pkg::op_e                        op_i,
  input  logic [btc_pkg::IDX_W-1:0]           idx_i,
  input  logic signed [btc_pkg::BND_W-1:0]    lo_i,
  input  logic signed [btc_pkg::BND_W-1:0]    hi_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output btc_pkg::res_t                       out_res_o
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int BW = btc_pkg::BND_W;
  localparam int PW = 2 * btc_pkg::BND_W;

  btc_pkg::op_e                  op_q;
  logic [btc_pkg::IDX_W-1:0]     idx_q;
  logic signed [BW-1:0]          lo_q;
  logic signed [BW-1:0]          hi_q;
  logic [CW-1:0]                 cnt_q;
  logic [CW-1:0]                 ptr_q;
  logic [NUM_ENTRIES-1:0]        valid_q;
  btc_pkg::res_t                 pend_q;
  logic                          pend_vld_q;
  btc_pkg::res_t                 out_q;
  logic                          out_vld_q;

  logic                          cur_we;
  logic                          sav_we;
  logic                          ord_we;
  logic [AW-1:0]                 wr_addr;
  logic [PW-1:0]                 cur_wdata;
  logic [PW-1:0]                 sav_wdata;
  logic                          ent_re;
  logic [AW-1:0]                 ent_raddr;
  logic [PW-1:0]                 cur_rd;
  logic [PW-1:0]                 sav_rd;
  logic [btc_pkg::IDX_W-1:0]     ord_e;

  logic                          in_range;
  logic                          hit;
  logic                          full;
  logic                          reg_ok;
  logic                          differ;
  logic                          out_free;
  logic                          walk_emit;
  logic                          out_load;
  btc_pkg::res_t                 pt_res;
  btc_pkg::res_t                 fin_res;
  btc_pkg::res_t                 new_pend;
  btc_pkg::res_t                 out_d;

  assign in_range = {1'b0, idx_q} < (btc_pkg::IDX_W + 1)'(NUM_ENTRIES);
  assign hit      = in_range && valid_q[idx_q[AW-1:0]];
  assign full     = cnt_q == CW'(NUM_ENTRIES);
  assign reg_ok   = !hit && in_range && !full;
  assign differ   = cur_rd != sav_rd;
  assign out_free = !out_vld_q || out_ready_i;

  assign walk_emit = cmd_i.walk_exec && (op_q == btc_pkg::OP_LIST) && differ;
  assign out_load  = cmd_i.point_exec || cmd_i.fin_load || (walk_emit && pend_vld_q);

  assign sts_o.out_free   = out_free;
  assign sts_o.walk_done  = ptr_q == cnt_q;
  assign sts_o.walk_stall = (op_q == btc_pkg::OP_LIST) && differ && pend_vld_q && !out_free;

  assign cur_we = (cmd_i.point_exec &&
                   (((op_q == btc_pkg::OP_REGISTER) && reg_ok) ||
                    ((op_q == btc_pkg::OP_UPDATE) && hit))) ||
                  (cmd_i.walk_exec && (op_q == btc_pkg::OP_DISCARD_ALL));
  assign sav_we = (cmd_i.point_exec &&
                   (((op_q == btc_pkg::OP_REGISTER) && reg_ok) ||
                    ((op_q == btc_pkg::OP_SAVE_ONE) && hit))) ||
                  (cmd_i.walk_exec && (op_q == btc_pkg::OP_SAVE_ALL));
  assign ord_we = cmd_i.point_exec && (op_q == btc_pkg::OP_REGISTER) && reg_ok;

  assign wr_addr   = cmd_i.walk_exec ? ord_e[AW-1:0] : idx_q[AW-1:0];
  assign cur_wdata = cmd_i.walk_exec ? sav_rd : {hi_q, lo_q};
  assign sav_wdata = (cmd_i.walk_exec || (op_q == btc_pkg::OP_SAVE_ONE)) ?
                     cur_rd : {hi_q, lo_q};
  assign ent_re    = cmd_i.rd_idx || cmd_i.ent_rd;
  assign ent_raddr = cmd_i.rd_idx ? idx_q[AW-1:0] : ord_e[AW-1:0];

  btc_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (wr_addr),
    .wdata_i (cur_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (cur_rd)
  );

  btc_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_sav_ram (
    .clk_i   (clk_i),
    .we_i    (sav_we),
    .waddr_i (wr_addr),
    .wdata_i (sav_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (sav_rd)
  );

  btc_ram #(.WIDTH(btc_pkg::IDX_W), .DEPTH(NUM_ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (idx_q),
    .re_i    (cmd_i.ord_rd),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ord_e)
  );

  always_comb begin
    pt_res         = '0;
    pt_res.var_out = idx_q;
    pt_res.last    = 1'b1;
    case (op_q)
      btc_pkg::OP_REGISTER: begin
        if (hit) begin
          pt_res.status = btc_pkg::ST_DUP;
        end else if (!reg_ok) begin
          pt_res.status = btc_pkg::ST_NOREG;
        end else begin
          pt_res.cur_lower   = lo_q;
          pt_res.cur_upper   = hi_q;
          pt_res.saved_lower = lo_q;
          pt_res.saved_upper = hi_q;
        end
      end
      btc_pkg::OP_UPDATE: begin
        if (!hit) begin
          pt_res.status = btc_pkg::ST_NOREG;
        end else begin
          pt_res.cur_lower   = lo_q;
          pt_res.cur_upper   = hi_q;
          pt_res.saved_lower = sav_rd[BW-1:0];
          pt_res.saved_upper = sav_rd[PW-1:BW];
        end
      end
      btc_pkg::OP_SAVE_ONE: begin
        if (!hit) begin
          pt_res.status = btc_pkg::ST_NOREG;
        end else begin
          pt_res.cur_lower   = cur_rd[BW-1:0];
          pt_res.cur_upper   = cur_rd[PW-1:BW];
          pt_res.saved_lower = cur_rd[BW-1:0];
          pt_res.saved_upper = cur_rd[PW-1:BW];
        end
      end
      btc_pkg::OP_READ: begin
        if (!hit) begin
          pt_res.status = btc_pkg::ST_NOREG;
        end else begin
          pt_res.cur_lower   = cur_rd[BW-1:0];
          pt_res.cur_upper   = cur_rd[PW-1:BW];
          pt_res.saved_lower = sav_rd[BW-1:0];
          pt_res.saved_upper = sav_rd[PW-1:BW];
        end
      end
      default: begin
        pt_res.status = btc_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    fin_res      = '0;
    fin_res.last = 1'b1;
    if (op_q == btc_pkg::OP_LIST) begin
      if (pend_vld_q) begin
        fin_res      = pend_q;
        fin_res.last = 1'b1;
      end else begin
        fin_res.status = btc_pkg::ST_NONE;
      end
    end
  end

  always_comb begin
    new_pend             = '0;
    new_pend.var_out     = ord_e;
    new_pend.cur_lower   = cur_rd[BW-1:0];
    new_pend.cur_upper   = cur_rd[PW-1:BW];
    new_pend.saved_lower = sav_rd[BW-1:0];
    new_pend.saved_upper = sav_rd[PW-1:BW];
  end

  always_comb begin
    if (cmd_i.point_exec) begin
      out_d = pt_res;
    end else if (cmd_i.fin_load) begin
      out_d = fin_res;
    end else begin
      out_d = pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= op_i;
      idx_q <= idx_i;
      lo_q  <= lo_i;
      hi_q  <= hi_i;
    end
    if (walk_emit) begin
      pend_q <= new_pend;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ptr_q      <= '0;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (ord_we) begin
        cnt_q                   <= cnt_q + CW'(1);
        valid_q[idx_q[AW-1:0]]  <= 1'b1;
      end
      if (cmd_i.latch_in) begin
        ptr_q      <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (cmd_i.walk_exec) begin
          ptr_q <= ptr_q + CW'(1);
        end
        if (walk_emit) begin
          pend_vld_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

[src/bound_table_with_checkpoint_core.sv]
// Top level of the bound table with checkpoint core.
// The slave stream takes one command item: tuser holds the operation, tdata the entry
// index and the lower and upper bounds. The master stream returns result items: tuser
// holds the status, tdata the entry index and its current and checkpoint bounds, and
// tlast marks the final result of a command.
// Register, update, save one and read first read the entry memories, whose read data
// is registered, and then load their result into the output register.
// Save all, discard all and list changes walk the registration order with an order
// read, an entry read and a write or compare per registered entry, and then load the
// final result.
// An unused operation goes straight to loading its final result.
// A list of changes holds one result back so that the final one can carry tlast.
// A new command is taken as soon as the previous one has issued its last result,
// even while that result still waits in the output register.
// Reset clears the valid bits, the registration count and the handshake state;
// there is no clearing pass, so the block is ready as soon as reset is released.
// When the receiver stalls, the result stays in the output register; a point
// operation, the final result or a list step that must emit waits until it frees up.
module bound_table_with_checkpoint_core #(
  parameter int NUM_ENTRIES = btc_pkg::NUM_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // var_index, lower_in, upper_in, zero fill
  input  logic [2:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // var_out, cur_lower_out, cur_upper_out,
                                       // saved_lower_out, saved_upper_out, zero fill
  output logic [1:0]   m_axis_tuser,   // status
  output logic         m_axis_tlast    // last
);

`include "bound_table_with_checkpoint_core_defines.svh"

  btc_pkg::cmd_t cmd;
  btc_pkg::sts_t sts;
  btc_pkg::res_t res;
  btc_pkg::op_e  op_in;
  logic          walk_cmd;

  assign op_in = btc_pkg::op_e'(s_axis_tuser);

  btc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (op_in),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  btc_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_in),
    .idx_i       (s_axis_tdata[5:0]),
    .lo_i        (s_axis_tdata[37:6]),
    .hi_i        (s_axis_tdata[69:38]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {2'b00, res.saved_upper, res.saved_lower,
                         res.cur_upper, res.cur_lower, res.var_out};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  assign walk_cmd = cmd.rd_idx || cmd.ord_rd || cmd.ent_rd || cmd.walk_exec;

  `BTC_ASSERT_SAME(a_load_when_free, clk_i, rst_ni, (cmd.point_exec || cmd.fin_load), sts.out_free)
  `BTC_ASSERT_SAME(a_single_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `BTC_ASSERT_SAME(a_ready_only_idle, clk_i, rst_ni, s_axis_tready, !walk_cmd)
  `BTC_ASSERT_NEXT(a_final_shown, clk_i, rst_ni, cmd.fin_load, (m_axis_tvalid && m_axis_tlast))

endmodule
